@@ design/srt_pkg.sv @@
package srt_pkg;

  localparam int unsigned TableDepthDef = 64;

  localparam int unsigned ActionW = 2;
  localparam int unsigned YearW   = 14;
  localparam int unsigned WordW   = 64;
  localparam int unsigned TailW   = 40;
  localparam int unsigned PosW    = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Field order makes a plain unsigned compare of the packed record match
  // year-then-name ordering.
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic [WordW-1:0] word_c;
    logic [TailW-1:0] word_d;
  } record_t;

  typedef struct packed {
    logic cap;    // latch compare result against incoming key
    logic apply;  // commit insert or delete shift
    logic del;    // shift toward head instead of toward tail
  } cell_ctl_t;

endpackage

@@ design/srt_ifs.sv @@
interface srt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [srt_pkg::ActionW-1:0]  action;
  logic [srt_pkg::YearW-1:0]    year;
  logic [srt_pkg::WordW-1:0]    name_chars_0_7;
  logic [srt_pkg::WordW-1:0]    name_chars_8_15;
  logic [srt_pkg::WordW-1:0]    name_chars_16_23;
  logic [srt_pkg::TailW-1:0]    name_chars_24_28;
  logic [srt_pkg::PosW-1:0]     position;

  modport source (
    output valid, action, year, name_chars_0_7, name_chars_8_15,
           name_chars_16_23, name_chars_24_28, position,
    input  ready
  );
  modport sink (
    input  valid, action, year, name_chars_0_7, name_chars_8_15,
           name_chars_16_23, name_chars_24_28, position,
    output ready
  );
endinterface

interface srt_res_if;
  logic                         valid;
  logic                         ready;
  logic [srt_pkg::StatusW-1:0]  status;
  logic [srt_pkg::YearW-1:0]    out_year;
  logic [srt_pkg::WordW-1:0]    out_chars_0_7;
  logic [srt_pkg::WordW-1:0]    out_chars_8_15;
  logic [srt_pkg::WordW-1:0]    out_chars_16_23;
  logic [srt_pkg::TailW-1:0]    out_chars_24_28;

  modport source (
    output valid, status, out_year, out_chars_0_7, out_chars_8_15,
           out_chars_16_23, out_chars_24_28,
    input  ready
  );
  modport sink (
    input  valid, status, out_year, out_chars_0_7, out_chars_8_15,
           out_chars_16_23, out_chars_24_28,
    output ready
  );
endinterface

@@ design/sorted_record_table.sv @@
// Sorted record table: up to TableDepth records, kept ascending by year and
// then by name bytes, one record per cell in a row of cells.
// cmd_i (valid/ready) takes one command word: insert a record, delete the
// record at a 1-based position, or read the record at a position.
// res_o (valid/ready) returns exactly one result word per command: status
// (done, bad position, table full) and, for a successful read, the record;
// all data fields are zero otherwise.
// Sequence: when the word is accepted, every cell compares its entry
// with the key and registers the result. In the apply step all cells
// shift in parallel and the result is loaded into the output register.
// No new command is taken until the compare-then-shift pass of the cell
// row is done; cmd_i.ready is low while a command is in flight.
// If res_o is stalled with a result pending, the next command waits in its
// shift step until the output register frees up; nothing is dropped.
// Reset (rst_ni low, asynchronous) empties the table by clearing the record
// count; cell contents are not cleared and are never read before written.
module sorted_record_table #(
  parameter int unsigned TableDepth = srt_pkg::TableDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  srt_cmd_if.sink   cmd_i,
  srt_res_if.source res_o
);
  import srt_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic {S_IDLE, S_APPLY} state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q;
  action_e          act_q;
  status_e          status_q;
  logic [CntW-1:0]  idx_q;
  record_t          key_q;

  logic             res_valid_q;
  status_e          res_status_q;
  record_t          res_rec_q;

  record_t          cmd_rec;
  logic             cmd_fire, apply_fire;
  logic [CmpW-1:0]  pos_w, cnt_w;
  logic             bad_pos, full;
  status_e          status_d;
  action_e          act_d;
  cell_ctl_t        ctl;
  record_t          rd_rec;

  record_t          rec   [TableDepth];
  logic             gt    [TableDepth];

  assign cmd_rec = '{year:   cmd_i.year,
                     word_a: cmd_i.name_chars_0_7,
                     word_b: cmd_i.name_chars_8_15,
                     word_c: cmd_i.name_chars_16_23,
                     word_d: cmd_i.name_chars_24_28};

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign apply_fire  = (state_q == S_APPLY) && (!res_valid_q || res_o.ready);

  assign pos_w   = CmpW'(cmd_i.position);
  assign cnt_w   = CmpW'(count_q);
  assign bad_pos = (pos_w == '0) || (pos_w > cnt_w);
  assign full    = (count_q == CntW'(TableDepth));
  assign act_d   = action_e'(cmd_i.action);

  always_comb begin
    case (act_d)
      ACT_INSERT: status_d = full ? ST_FULL : ST_DONE;
      ACT_DELETE,
      ACT_READ:   status_d = bad_pos ? ST_BAD_POS : ST_DONE;
      default:    status_d = ST_DONE;
    endcase
  end

  assign ctl.cap   = cmd_fire;
  assign ctl.apply = apply_fire && (status_q == ST_DONE) &&
                     ((act_q == ACT_INSERT) || (act_q == ACT_DELETE));
  assign ctl.del   = (act_q == ACT_DELETE);

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    record_t prev_rec, next_rec;
    logic    prev_gt;
    if (i == 0) begin : g_head
      assign prev_rec = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_rec = rec[i-1];
      assign prev_gt  = gt[i-1];
    end
    if (i == TableDepth - 1) begin : g_tail
      assign next_rec = '0;
    end else begin : g_body
      assign next_rec = rec[i+1];
    end

    srt_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cmp_key_i  (cmd_rec),
      .wr_key_i   (key_q),
      .count_i    (count_q),
      .del_idx_i  (idx_q),
      .prev_rec_i (prev_rec),
      .prev_gt_i  (prev_gt),
      .next_rec_i (next_rec),
      .rec_o      (rec[i]),
      .gt_o       (gt[i])
    );
  end

  // one-hot select of the addressed cell
  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (idx_q == CntW'(i)) begin
        rd_rec = rd_rec | rec[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (apply_fire) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_fire) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_fire) begin
            state_q <= S_IDLE;
            if (ctl.apply) begin
              count_q <= ctl.del ? count_q - CntW'(1) : count_q + CntW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      act_q    <= act_d;
      status_q <= status_d;
      idx_q    <= CntW'(pos_w - CmpW'(1));
      key_q    <= cmd_rec;
    end
    if (apply_fire) begin
      res_status_q <= status_q;
      res_rec_q    <= ((act_q == ACT_READ) && (status_q == ST_DONE)) ? rd_rec : '0;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.status          = res_status_q;
  assign res_o.out_year        = res_rec_q.year;
  assign res_o.out_chars_0_7   = res_rec_q.word_a;
  assign res_o.out_chars_8_15  = res_rec_q.word_b;
  assign res_o.out_chars_16_23 = res_rec_q.word_c;
  assign res_o.out_chars_24_28 = res_rec_q.word_d;

endmodule

@@ design/srt_cell.sv @@
module srt_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic              clk_i,
  input  srt_pkg::cell_ctl_t ctl_i,
  input  srt_pkg::record_t  cmp_key_i,
  input  srt_pkg::record_t  wr_key_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [CntW-1:0]   del_idx_i,
  input  srt_pkg::record_t  prev_rec_i,
  input  logic              prev_gt_i,
  input  srt_pkg::record_t  next_rec_i,
  output srt_pkg::record_t  rec_o,
  output logic              gt_o
);
  import srt_pkg::*;

  localparam logic [CntW-1:0] Pos = CntW'(Idx);

  record_t rec_q, rec_d;
  logic    gt_q, gt_d;
  logic    occupied;

  assign occupied = Pos < count_i;
  assign gt_d     = occupied && (rec_q > cmp_key_i);

  always_comb begin
    if (ctl_i.del) begin
      rec_d = (Pos >= del_idx_i) ? next_rec_i : rec_q;
    end else if (prev_gt_i) begin
      rec_d = prev_rec_i;
    end else if (gt_q || (Pos == count_i)) begin
      // first entry greater than the key, or the first free slot
      rec_d = wr_key_i;
    end else begin
      rec_d = rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      gt_q <= gt_d;
    end
    if (ctl_i.apply) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;
  assign gt_o  = gt_q;

endmodule

@@ design/srt_chk.sv @@
module srt_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cmd_valid_i,
  input logic                        cmd_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [srt_pkg::StatusW-1:0] status_i,
  input logic [srt_pkg::YearW-1:0]   out_year_i,
  input logic [srt_pkg::WordW-1:0]   out_a_i,
  input logic [srt_pkg::WordW-1:0]   out_b_i,
  input logic [srt_pkg::WordW-1:0]   out_c_i,
  input logic [srt_pkg::TailW-1:0]   out_d_i
);
  import srt_pkg::*;

  // one command in flight: no second word right after an accepted one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) |=> !cmd_ready_i)
    else $error("command taken while previous still in flight");

  // a command accepted while no result is pending produces its result without a stall
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i && !res_valid_i) |=> ##1 res_valid_i)
    else $error("result not produced on time");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(status_i)))
    else $error("pending result dropped or changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (status_i == ST_DONE || status_i == ST_BAD_POS ||
                     status_i == ST_FULL))
    else $error("undefined status code");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && status_i != ST_DONE) |->
      (out_year_i == '0 && out_a_i == '0 && out_b_i == '0 &&
       out_c_i == '0 && out_d_i == '0))
    else $error("record data on a failed command");

endmodule

bind sorted_record_table srt_chk u_srt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .status_i    (res_o.status),
  .out_year_i  (res_o.out_year),
  .out_a_i     (res_o.out_chars_0_7),
  .out_b_i     (res_o.out_chars_8_15),
  .out_c_i     (res_o.out_chars_16_23),
  .out_d_i     (res_o.out_chars_24_28)
);
